/* rtl/fasta_record_parser_defines.svh */
// assertion macros for the fasta record parser
`ifndef FASTA_RECORD_PARSER_DEFINES_SVH
`define FASTA_RECORD_PARSER_DEFINES_SVH
`ifndef ASSERT_OFF
`define FRP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FRP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define FRP_ASSERT(label, clk, rst_n, prop, msg)
`define FRP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/frp_pkg.sv */
`default_nettype none
package frp_pkg;

	localparam int DEF_LENGTH_BITS = 32;
	localparam int DEF_ID_BITS     = 32;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam int MIN_LEN_W   = 10;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_MIN_LENGTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_FIRST_ID   = 1'b1;

	localparam logic [7:0] CHAR_GT = 8'h3E;
	localparam logic [7:0] CHAR_NL = 8'h0A;
	localparam logic [7:0] CHAR_SP = 8'h20;

	typedef enum logic [1:0] {
		KIND_NAME    = 2'd0,
		KIND_COMMENT = 2'd1,
		KIND_SEQ     = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	// one accepted byte: an optional character result, then an optional record end
	typedef struct packed {
		logic       has_char;
		kind_t      char_kind;
		logic [7:0] char_value;
		logic       has_end;
		logic       too_short;
		logic       had_header;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

/* rtl/frp_front.sv */
`default_nettype none
module frp_front import frp_pkg::*; #(
	parameter int LENGTH_BITS = DEF_LENGTH_BITS,
	parameter int ID_BITS     = DEF_ID_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [7:0]             byte_value,
	input  wire logic                   end_of_chunk,
	input  wire logic                   take,
	input  wire logic                   cfg_valid,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                        push,
	output entry_t                      ent,
	output logic [ID_BITS-1:0]          ent_id,
	output logic [LENGTH_BITS-1:0]      ent_len
);

	localparam int CMP_W = (LENGTH_BITS > MIN_LEN_W) ? LENGTH_BITS : MIN_LEN_W;

	typedef enum logic [1:0] {
		PH_START   = 2'd0,
		PH_NAME    = 2'd1,
		PH_COMMENT = 2'd2,
		PH_SEQ     = 2'd3
	} phase_t;

	phase_t                 phase_q, phase_n;
	logic                   after_nl_q, after_nl_n;
	logic                   hdr_seen_q, hdr_seen_n;
	logic [ID_BITS-1:0]     id_q, id_n;
	logic [LENGTH_BITS-1:0] len_q, len_n;
	logic [MIN_LEN_W-1:0]   min_len_q;
	logic                   open_rec;
	logic                   seq_en;
	logic                   end_en;

	always_comb begin
		phase_n    = phase_q;
		after_nl_n = after_nl_q;
		hdr_seen_n = hdr_seen_q;
		id_n       = id_q;
		len_n      = len_q;
		open_rec   = 1'b1;
		seq_en     = 1'b0;
		end_en     = 1'b0;
		ent        = '0;
		ent_len    = '0;

		unique case (phase_q)
			PH_START: begin
				if (end_of_chunk) begin
					open_rec = 1'b0;
				end else begin
					len_n = '0;
					if (byte_value == CHAR_GT) begin
						hdr_seen_n = 1'b1;
						phase_n    = PH_NAME;
					end else begin
						hdr_seen_n = 1'b0;
						phase_n    = PH_SEQ;
						seq_en     = 1'b1;
					end
				end
			end
			PH_NAME, PH_COMMENT: begin
				if (byte_value == CHAR_NL) begin
					phase_n    = PH_SEQ;
					after_nl_n = 1'b1;
				end else if (phase_q == PH_NAME && byte_value == CHAR_SP) begin
					phase_n = PH_COMMENT;
				end else begin
					ent.has_char   = 1'b1;
					ent.char_kind  = (phase_q == PH_NAME) ? KIND_NAME : KIND_COMMENT;
					ent.char_value = byte_value;
				end
			end
			PH_SEQ: begin
				if (after_nl_q && byte_value == CHAR_GT) begin
					end_en = 1'b1;
					if (end_of_chunk) begin
						open_rec = 1'b0;
					end else begin
						hdr_seen_n = 1'b1;
						phase_n    = PH_NAME;
					end
				end else begin
					seq_en = 1'b1;
				end
			end
			default: begin
				phase_n = PH_START;
			end
		endcase

		// sequence byte, newlines dropped, saturating count
		if (seq_en) begin
			if (byte_value == CHAR_NL) begin
				after_nl_n = 1'b1;
			end else begin
				after_nl_n = 1'b0;
				if (len_n != '1) begin
					len_n = len_n + 1'b1;
				end
				ent.has_char   = 1'b1;
				ent.char_kind  = KIND_SEQ;
				ent.char_value = byte_value;
			end
		end

		if (end_of_chunk && open_rec) begin
			end_en = 1'b1;
		end

		if (end_en) begin
			ent.has_end    = 1'b1;
			ent.too_short  = CMP_W'(len_n) < CMP_W'(min_len_q);
			ent.had_header = hdr_seen_q;
			ent_len        = len_n;
			id_n           = id_q + 1'b1;
			len_n          = '0;
		end

		if (end_of_chunk) begin
			phase_n    = PH_START;
			after_nl_n = 1'b1;
			hdr_seen_n = 1'b0;
			len_n      = '0;
		end
	end

	assign push   = take && (ent.has_char || ent.has_end);
	assign ent_id = id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			after_nl_q <= 1'b1;
			hdr_seen_q <= 1'b0;
			id_q       <= '0;
			len_q      <= '0;
			min_len_q  <= '0;
		end else begin
			if (take) begin
				phase_q    <= phase_n;
				after_nl_q <= after_nl_n;
				hdr_seen_q <= hdr_seen_n;
				id_q       <= id_n;
				len_q      <= len_n;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MIN_LENGTH: min_len_q <= cfg_data[MIN_LEN_W-1:0];
					REG_FIRST_ID:   id_q      <= ID_BITS'(cfg_data);
					default:        min_len_q <= min_len_q;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/frp_queue.sv */
`default_nettype none
module frp_queue import frp_pkg::*; #(
	parameter int WIDTH = ENTRY_W,
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      head_data,
	output logic                  full,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/frp_back.sv */
`default_nettype none
module frp_back import frp_pkg::*; #(
	parameter int LENGTH_BITS = DEF_LENGTH_BITS,
	parameter int ID_BITS     = DEF_ID_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_empty,
	input  entry_t                      head_ent,
	input  wire logic [ID_BITS-1:0]     head_id,
	input  wire logic [LENGTH_BITS-1:0] head_len,
	output logic                        pop,
	input  wire logic                   result_stall,
	output logic                        result_valid,
	output kind_t                       kind,
	output logic [7:0]                  char_value,
	output logic [ID_BITS-1:0]          record_id,
	output logic [LENGTH_BITS-1:0]      seq_length,
	output logic                        too_short,
	output logic                        had_header,
	output logic                        run_last
);

	logic                   valid_q;
	logic                   sel_q;
	kind_t                  kind_q;
	logic [7:0]             char_q;
	logic [ID_BITS-1:0]     id_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic                   short_q;
	logic                   hdr_q;
	logic                   last_q;
	logic                   load;
	logic                   emit_char;

	assign load      = !valid_q || !result_stall;
	assign emit_char = !sel_q && head_ent.has_char;
	assign pop       = load && !q_empty && !(emit_char && head_ent.has_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (load) begin
			valid_q <= !q_empty;
			if (!q_empty) begin
				sel_q <= emit_char && head_ent.has_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			id_q <= head_id;
			if (emit_char) begin
				kind_q  <= head_ent.char_kind;
				char_q  <= head_ent.char_value;
				len_q   <= '0;
				short_q <= 1'b0;
				hdr_q   <= 1'b0;
				last_q  <= !head_ent.has_end;
			end else begin
				kind_q  <= KIND_END;
				char_q  <= '0;
				len_q   <= head_len;
				short_q <= head_ent.too_short;
				hdr_q   <= head_ent.had_header;
				last_q  <= 1'b1;
			end
		end
	end

	assign result_valid = valid_q;
	assign kind         = kind_q;
	assign char_value   = char_q;
	assign record_id    = id_q;
	assign seq_length   = len_q;
	assign too_short    = short_q;
	assign had_header   = hdr_q;
	assign run_last     = last_q;

endmodule
`default_nettype wire

/* rtl/fasta_record_parser.sv */
// fasta record parser: one byte transfer per cycle unless byte_stall (queue full) holds it, up to two results per byte
// a result passes through the queue and then the output register after its byte transfer
// throughput: one byte and one result per cycle while neither side stalls; a byte with two
// results occupies the single output register for both of them, the queue absorbs it
// reset: asynchronous active-low arst_n clears parse state, queue and output
// valid; min_length and the record id counter reset to zero
`default_nettype none
`include "fasta_record_parser_defines.svh"
module fasta_record_parser import frp_pkg::*; #(
	parameter int LENGTH_BITS = DEF_LENGTH_BITS,
	parameter int ID_BITS     = DEF_ID_BITS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   byte_valid,
	output logic                        byte_stall,
	input  wire logic [7:0]             byte_value,
	input  wire logic                   end_of_chunk,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output logic [1:0]                  kind,
	output logic [7:0]                  char_value,
	output logic [ID_BITS-1:0]          record_id,
	output logic [LENGTH_BITS-1:0]      seq_length,
	output logic                        too_short,
	output logic                        had_header,
	output logic                        run_last,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int Q_W = ID_BITS + LENGTH_BITS + ENTRY_W;

	logic                   take;
	logic                   push;
	entry_t                 f_ent;
	logic [ID_BITS-1:0]     f_id;
	logic [LENGTH_BITS-1:0] f_len;
	logic [Q_W-1:0]         q_head;
	logic                   q_full;
	logic                   q_empty;
	logic                   pop;
	entry_t                 h_ent;
	logic [ID_BITS-1:0]     h_id;
	logic [LENGTH_BITS-1:0] h_len;
	kind_t                  b_kind;

	assign cfg_ready  = 1'b1;
	assign byte_stall = q_full;
	assign take       = byte_valid && !byte_stall;

	frp_front #(
		.LENGTH_BITS(LENGTH_BITS),
		.ID_BITS    (ID_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_value  (byte_value),
		.end_of_chunk(end_of_chunk),
		.take        (take),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.ent         (f_ent),
		.ent_id      (f_id),
		.ent_len     (f_len)
	);

	frp_queue #(
		.WIDTH(Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({f_id, f_len, f_ent}),
		.pop      (pop),
		.head_data(q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	assign h_id  = q_head[Q_W-1 -: ID_BITS];
	assign h_len = q_head[ENTRY_W +: LENGTH_BITS];
	assign h_ent = entry_t'(q_head[ENTRY_W-1:0]);

	frp_back #(
		.LENGTH_BITS(LENGTH_BITS),
		.ID_BITS    (ID_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.head_ent    (h_ent),
		.head_id     (h_id),
		.head_len    (h_len),
		.pop         (pop),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.kind        (b_kind),
		.char_value  (char_value),
		.record_id   (record_id),
		.seq_length  (seq_length),
		.too_short   (too_short),
		.had_header  (had_header),
		.run_last    (run_last)
	);

	assign kind = b_kind;

	`FRP_ASSERT_IMPL(a_end_is_last, clk, arst_n, result_valid && b_kind == KIND_END, run_last, "record end not last result of its byte")
	`FRP_ASSERT_IMPL(a_char_fields_zero, clk, arst_n, result_valid && b_kind != KIND_END, seq_length == '0 && !too_short && !had_header, "character result carries record-end fields")
	`FRP_ASSERT_IMPL(a_empty_not_stalled, clk, arst_n, q_empty, !byte_stall, "input stalled with empty queue")
	`FRP_ASSERT(a_pop_needs_entry, clk, arst_n, pop |-> !q_empty, "queue popped while empty")

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
	import frp_pkg::*;

	typedef enum logic [1:0] {AT_START, IN_NAME, IN_COMMENT, IN_SEQ} parse_phase_t;
	typedef enum {RX_FREE, RX_HALF, RX_SPARSE, RX_HOLD} rx_mode_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last_of_chunk;
	} chunk_byte_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
		logic [31:0] id;
		logic [31:0] len;
		logic        shrt;
		logic        hdr;
		logic        last;
	} parse_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	logic [7:0] byte_value = 8'h00;
	logic end_of_chunk = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] char_value;
	logic [31:0] record_id;
	logic [31:0] seq_length;
	logic too_short;
	logic had_header;
	logic run_last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	chunk_byte_t bytes_to_send[$];
	parse_result_t parse_results_due[$];
	logic [7:0] chunk_text[$];
	int unsigned bytes_queued = 0;
	int unsigned fail_count = 0;
	int unsigned hold_requests = 0;
	logic byte_took = 1'b0;

	// parser state as predicted
	parse_phase_t ps_phase = AT_START;
	bit ps_line_start = 1'b1;
	logic [31:0] ps_id = '0;
	logic [31:0] ps_len = '0;
	bit ps_header = 1'b0;
	logic [MIN_LEN_W-1:0] min_len = '0;

	fasta_record_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_value(byte_value),
		.end_of_chunk(end_of_chunk),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.char_value(char_value),
		.record_id(record_id),
		.seq_length(seq_length),
		.too_short(too_short),
		.had_header(had_header),
		.run_last(run_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic parse_result_t char_result(kind_t k, logic [7:0] b);
		return '{k, b, ps_id, 32'd0, 1'b0, 1'b0, 1'b0};
	endfunction

	function automatic parse_result_t close_record();
		parse_result_t r;
		r = '{KIND_END, 8'h00, ps_id, ps_len, ps_len < {22'd0, min_len}, ps_header, 1'b0};
		ps_id = ps_id + 32'd1;
		ps_len = '0;
		return r;
	endfunction

	function automatic bit take_seq_byte(input logic [7:0] b, output parse_result_t r);
		r = '0;
		if (b == CHAR_NL) begin
			ps_line_start = 1'b1;
			return 1'b0;
		end
		ps_line_start = 1'b0;
		if (ps_len != '1)
			ps_len = ps_len + 32'd1;
		r = char_result(KIND_SEQ, b);
		return 1'b1;
	endfunction

	task automatic parse_byte(logic [7:0] b, logic eoc);
		parse_result_t outs[$];
		parse_result_t r;
		bit open;
		open = 1'b1;
		case (ps_phase)
			AT_START: begin
				if (eoc) begin
					open = 1'b0;
				end else begin
					ps_len = '0;
					if (b == CHAR_GT) begin
						ps_header = 1'b1;
						ps_phase = IN_NAME;
					end else begin
						ps_header = 1'b0;
						ps_phase = IN_SEQ;
						if (take_seq_byte(b, r))
							outs.insert(outs.size(), r);
					end
				end
			end
			IN_NAME, IN_COMMENT: begin
				if (b == CHAR_NL) begin
					ps_phase = IN_SEQ;
					ps_line_start = 1'b1;
				end else if (ps_phase == IN_NAME && b == CHAR_SP) begin
					ps_phase = IN_COMMENT;
				end else begin
					r = char_result(ps_phase == IN_NAME ? KIND_NAME : KIND_COMMENT, b);
					outs.insert(outs.size(), r);
				end
			end
			default: begin
				if (ps_line_start && b == CHAR_GT) begin
					outs.insert(outs.size(), close_record());
					if (eoc) begin
						open = 1'b0;
					end else begin
						ps_header = 1'b1;
						ps_phase = IN_NAME;
					end
				end else if (take_seq_byte(b, r)) begin
					outs.insert(outs.size(), r);
				end
			end
		endcase
		if (eoc) begin
			if (open)
				outs.insert(outs.size(), close_record());
			ps_phase = AT_START;
			ps_line_start = 1'b1;
			ps_header = 1'b0;
			ps_len = '0;
		end
		if (outs.size() != 0) begin
			r = outs.pop_back();
			r.last = 1'b1;
			outs.insert(outs.size(), r);
		end
		foreach (outs[i])
			parse_results_due.insert(parse_results_due.size(), outs[i]);
	endtask

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			fail_count++;
		end
	endfunction

	task automatic check_result();
		parse_result_t want;
		if (parse_results_due.size() == 0) begin
			$error("result with none due: kind %0d char %0h id %0h", kind, char_value, record_id);
			fail_count++;
		end else begin
			want = parse_results_due.pop_front();
			check_field("kind", want.kind, kind);
			check_field("char_value", want.ch, char_value);
			check_field("record_id", want.id, record_id);
			check_field("seq_length", want.len, seq_length);
			check_field("too_short", want.shrt, too_short);
			check_field("had_header", want.hdr, had_header);
			check_field("run_last", want.last, run_last);
		end
	endtask

	// monitor: config writes, byte transfers, result transfers
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_took <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MIN_LENGTH: min_len = cfg_data[MIN_LEN_W-1:0];
					REG_FIRST_ID: ps_id = cfg_data;
					default: ;
				endcase
			end
			byte_took <= byte_valid && !byte_stall;
			if (byte_valid && !byte_stall)
				parse_byte(byte_value, end_of_chunk);
			if (result_valid && !result_stall)
				check_result();
		end
	end

	// byte driver: bursts with random gaps
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	always @(negedge clk) begin : drive_bytes
		chunk_byte_t nxt;
		if (arst_n && (!byte_valid || byte_took)) begin
			if (gap_left != 0) begin
				gap_left--;
				byte_valid <= 1'b0;
			end else if (bytes_to_send.size() != 0) begin
				nxt = bytes_to_send.pop_front();
				byte_valid <= 1'b1;
				byte_value <= nxt.value;
				end_of_chunk <= nxt.last_of_chunk;
				if (burst_left != 0) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
						: $urandom_range(0, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// result stall pattern
	rx_mode_t rx_mode = RX_FREE;
	int unsigned rx_left = 0;
	int unsigned holds_done = 0;
	always @(negedge clk) begin
		if (holds_done != hold_requests) begin
			holds_done = hold_requests;
			rx_mode = RX_HOLD;
			rx_left = 150;
		end else if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(10, 80);
		end
		rx_left--;
		case (rx_mode)
			RX_FREE: result_stall <= 1'b0;
			RX_HALF: result_stall <= 1'($urandom_range(0, 1));
			RX_SPARSE: result_stall <= ($urandom_range(0, 7) == 0);
			default: result_stall <= 1'b1;
		endcase
	end

	task automatic push_byte(logic [7:0] b, logic eoc);
		bytes_to_send.insert(bytes_to_send.size(), '{b, eoc});
		bytes_queued++;
	endtask

	task automatic push_text(string s, bit eoc_at_end);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], eoc_at_end && i == s.len() - 1);
	endtask

	task automatic flush_chunk(bit eoc_at_end);
		foreach (chunk_text[i])
			push_byte(chunk_text[i], eoc_at_end && i == chunk_text.size() - 1);
		chunk_text.delete();
	endtask

	task automatic add_char(logic [7:0] b);
		chunk_text.insert(chunk_text.size(), b);
	endtask

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 3))
			0: return CHAR_GT;
			1: return CHAR_NL;
			2: return CHAR_SP;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic add_header();
		add_char(CHAR_GT);
		repeat ($urandom_range(0, 6))
			add_char(8'($urandom_range(33, 126)));
		if ($urandom_range(0, 3) != 0) begin
			add_char(CHAR_SP);
			repeat ($urandom_range(0, 10)) begin
				if ($urandom_range(0, 5) == 0)
					add_char(CHAR_SP);
				else if ($urandom_range(0, 9) == 0)
					add_char(8'h0D);
				else
					add_char(8'($urandom_range(33, 126)));
			end
		end
		add_char(CHAR_NL);
	endtask

	task automatic add_sequence();
		string bases;
		int unsigned n;
		bases = "ACGTN";
		repeat ($urandom_range(0, 3)) begin
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 12);
			repeat (n) begin
				if ($urandom_range(0, 19) == 0)
					add_char(8'($urandom_range(0, 255)));
				else
					add_char(bases[$urandom_range(0, 4)]);
			end
			if ($urandom_range(0, 7) == 0)
				add_char(8'h0D);
			if ($urandom_range(0, 5) != 0)
				add_char(CHAR_NL);
		end
	endtask

	task automatic add_random_chunk();
		int unsigned cut;
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 12))
				add_char(noise_byte());
			flush_chunk($urandom_range(0, 3) != 0);
		end else begin
			if ($urandom_range(0, 3) == 0)
				add_sequence();
			repeat ($urandom_range(1, 3)) begin
				add_header();
				add_sequence();
			end
			// broken chunk: cut at a random point
			if ($urandom_range(0, 4) == 0) begin
				cut = $urandom_range(1, chunk_text.size());
				while (chunk_text.size() > cut)
					void'(chunk_text.pop_back());
			end
			flush_chunk(1'b1);
		end
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (bytes_to_send.size() != 0 || byte_valid || parse_results_due.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		wait_idle();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(int unsigned n_items, bit pause_midway);
		int unsigned start;
		bit paused;
		start = bytes_queued;
		paused = 1'b0;
		hold_requests++;
		while (bytes_queued - start < n_items) begin
			add_random_chunk();
			if (pause_midway && !paused && bytes_queued - start >= n_items / 2) begin
				wait_idle();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_FIRST_ID, 32'hFFFF_FFFF);
		write_reg(REG_MIN_LENGTH, 32'd0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_text("A\n>", 1'b1);
		push_text(">n  c\015\n>x\nG\n", 1'b1);
		push_text(">h", 1'b1);
		push_text(">", 1'b1);
		push_text("\n>", 1'b1);

		write_reg(REG_MIN_LENGTH, 32'd1023);
		write_reg(REG_FIRST_ID, 32'd0);
		run_phase(200, 1'b0);
		write_reg(REG_MIN_LENGTH, $urandom_range(1, 30));
		write_reg(REG_FIRST_ID, $urandom);
		run_phase(250, 1'b1);
		write_reg(REG_MIN_LENGTH, 32'd5);
		write_reg(REG_FIRST_ID, 32'hFFFF_FFFE);
		run_phase(200, 1'b0);
		write_reg(REG_MIN_LENGTH, $urandom_range(0, 40));
		write_reg(REG_FIRST_ID, $urandom);
		run_phase(250, 1'b0);
		write_reg(REG_MIN_LENGTH, 32'd0);
		write_reg(REG_FIRST_ID, 32'h7FFF_FFFF);
		run_phase(200, 1'b0);

		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
